// ===== rtl/sdt_pkg.sv =====
package sdt_pkg;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_FIN_DAY,
    ST_DIV_HOUR,
    ST_FIN_HOUR,
    ST_DIV_MIN,
    ST_FIN_MIN,
    ST_YEAR,
    ST_MONTH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_day;
    logic fin_day;
    logic div_hour;
    logic fin_hour;
    logic div_min;
    logic fin_min;
    logic year_step;
    logic month_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic year_hit;
    logic month_hit;
  } sts_t;

  // reciprocals of the odd divisor parts, exact over each operand range
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675 rounded up
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225 rounded up
  localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15 rounded up

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
  localparam logic [11:0] FIRST_YEAR       = 12'd1970;
  localparam logic [4:0]  LEAP_FEB_DAYS    = 5'd29;
  localparam logic [1:0]  LEAP_MASK        = 2'd3;

  // days in month, month index from 0
  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx)
      4'd1: begin
        len = leap ? LEAP_FEB_DAYS : 5'd28;
      end
      4'd3, 4'd5, 4'd8, 4'd10: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/sdt_ctrl.sv =====
module sdt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sdt_pkg::sts_t sts,
  output sdt_pkg::cmd_t cmd,
  output logic          busy
);

  sdt_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdt_pkg::ST_IDLE: begin
        if (start) state_nxt = sdt_pkg::ST_DIV_DAY;
      end
      sdt_pkg::ST_DIV_DAY: begin
        state_nxt = sdt_pkg::ST_FIN_DAY;
      end
      sdt_pkg::ST_FIN_DAY: begin
        state_nxt = sdt_pkg::ST_DIV_HOUR;
      end
      sdt_pkg::ST_DIV_HOUR: begin
        state_nxt = sdt_pkg::ST_FIN_HOUR;
      end
      sdt_pkg::ST_FIN_HOUR: begin
        state_nxt = sdt_pkg::ST_DIV_MIN;
      end
      sdt_pkg::ST_DIV_MIN: begin
        state_nxt = sdt_pkg::ST_FIN_MIN;
      end
      sdt_pkg::ST_FIN_MIN: begin
        state_nxt = sdt_pkg::ST_YEAR;
      end
      sdt_pkg::ST_YEAR: begin
        if (sts.year_hit) state_nxt = sdt_pkg::ST_MONTH;
      end
      sdt_pkg::ST_MONTH: begin
        if (sts.month_hit) state_nxt = sdt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sdt_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      sdt_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      sdt_pkg::ST_DIV_DAY: begin
        cmd.div_day = 1'b1;
      end
      sdt_pkg::ST_FIN_DAY: begin
        cmd.fin_day = 1'b1;
      end
      sdt_pkg::ST_DIV_HOUR: begin
        cmd.div_hour = 1'b1;
      end
      sdt_pkg::ST_FIN_HOUR: begin
        cmd.fin_hour = 1'b1;
      end
      sdt_pkg::ST_DIV_MIN: begin
        cmd.div_min = 1'b1;
      end
      sdt_pkg::ST_FIN_MIN: begin
        cmd.fin_min = 1'b1;
      end
      sdt_pkg::ST_YEAR: begin
        cmd.year_step = 1'b1;
      end
      sdt_pkg::ST_MONTH: begin
        cmd.month_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/sdt_dpath.sv =====
module sdt_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  sdt_pkg::cmd_t cmd,
  input  logic [31:0]   in_epoch_seconds,
  output sdt_pkg::sts_t sts,
  output logic          out_valid,
  output logic [11:0]   out_year,
  output logic [3:0]    out_month,
  output logic [4:0]    out_day,
  output logic [4:0]    out_hour,
  output logic [5:0]    out_minute,
  output logic [5:0]    out_second
);

  logic [31:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] days_r, days_nxt;
  logic [11:0] yr_r, yr_nxt;
  logic [3:0]  mon_idx_r, mon_idx_nxt;
  logic [4:0]  hr_r, hr_nxt;
  logic [5:0]  mn_r, mn_nxt;
  logic [5:0]  sc_r, sc_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [32:0] day_back;
  logic [16:0] hour_back;
  logic [16:0] min_back;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // quotients by reciprocal multiply, power of two of each divisor shifted off first
  assign day_prod  = {26'b0, rem_r[31:7]} * {25'b0, sdt_pkg::DAY_RECIP};
  assign hour_prod = {14'b0, rem_r[16:4]} * {13'b0, sdt_pkg::HOUR_RECIP};
  assign min_prod  = {11'b0, rem_r[11:2]} * {10'b0, sdt_pkg::MIN_RECIP};

  // quotient times divisor, taken off to leave the remainder
  assign day_back  = {17'b0, quo_r} * {16'b0, sdt_pkg::SECS_PER_DAY};
  assign hour_back = {12'b0, hr_r} * sdt_pkg::SECS_PER_HOUR;
  assign min_back  = {11'b0, mn_r} * sdt_pkg::SECS_PER_MIN;

  // year and month lengths
  assign leap = ((yr_r[1:0] & sdt_pkg::LEAP_MASK) == 2'b00);
  assign ylen = leap ? (sdt_pkg::DAYS_COMMON_YEAR + 9'd1) : sdt_pkg::DAYS_COMMON_YEAR;
  assign mlen = sdt_pkg::month_len(mon_idx_r, leap);

  assign sts.year_hit  = (days_r <= {7'b0, ylen});
  assign sts.month_hit = (days_r <= {11'b0, mlen});

  // next values
  always_comb begin
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    days_nxt      = days_r;
    yr_nxt        = yr_r;
    mon_idx_nxt   = mon_idx_r;
    hr_nxt        = hr_r;
    mn_nxt        = mn_r;
    sc_nxt        = sc_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_valid_nxt = 1'b0;
    if (cmd.load) begin
      rem_nxt = in_epoch_seconds;
    end
    if (cmd.div_day) begin
      quo_nxt = day_prod[50:35];
    end
    // day count from 1, time of day goes on to the hour division
    if (cmd.fin_day) begin
      days_nxt = quo_r + 16'd1;
      rem_nxt  = rem_r - day_back[31:0];
    end
    if (cmd.div_hour) begin
      hr_nxt = hour_prod[25:21];
    end
    if (cmd.fin_hour) begin
      rem_nxt = {15'b0, rem_r[16:0] - hour_back};
    end
    if (cmd.div_min) begin
      mn_nxt = min_prod[19:14];
    end
    // seconds left are below 60, so the low bits of the difference suffice
    if (cmd.fin_min) begin
      sc_nxt      = rem_r[5:0] - min_back[5:0];
      yr_nxt      = sdt_pkg::FIRST_YEAR;
      mon_idx_nxt = '0;
    end
    // take off one whole year
    if (cmd.year_step && !sts.year_hit) begin
      days_nxt = days_r - {7'b0, ylen};
      yr_nxt   = yr_r + 12'd1;
    end
    // walk one month, or finish the beat
    if (cmd.month_step) begin
      if (sts.month_hit) begin
        out_month_nxt = mon_idx_r + 4'd1;
        out_day_nxt   = days_r[4:0];
        out_valid_nxt = 1'b1;
      end else begin
        days_nxt    = days_r - {11'b0, mlen};
        mon_idx_nxt = mon_idx_r + 4'd1;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    days_r      <= days_nxt;
    yr_r        <= yr_nxt;
    mon_idx_r   <= mon_idx_nxt;
    hr_r        <= hr_nxt;
    mn_r        <= mn_nxt;
    sc_r        <= sc_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_year   = yr_r;
  assign out_month  = out_month_r;
  assign out_day    = out_day_r;
  assign out_hour   = hr_r;
  assign out_minute = mn_r;
  assign out_second = sc_r;

endmodule

// ===== rtl/seconds_to_datetime_top.sv =====
// sequence: a beat is loaded on the accepting edge, then come the day, hour and
// minute divisions by reciprocal multiply, then the year walk from 1970 and the
// month walk, one year or month per step; the month walk ends with the strobe.
// throughput: one beat at a time; busy drops in the strobe cycle, so a new
// beat can be taken while the result is shown. results cannot be stalled.
// reset: synchronous active-low rst_n returns the controller to idle.
module seconds_to_datetime_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  sdt_pkg::cmd_t cmd;
  sdt_pkg::sts_t sts;

  // sequencer
  sdt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // divider, year and month walk
  sdt_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_epoch_seconds (in_epoch_seconds),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

endmodule

// ===== tb/sv/seconds_to_datetime_top_tb.sv =====
module seconds_to_datetime_top_tb;

  localparam int unsigned SECS_IN_DAY  = 86400;
  localparam int unsigned SECS_IN_HOUR = 3600;
  localparam int unsigned SECS_IN_MIN  = 60;
  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 230;
  localparam int          RANDOM_BEATS = 1800;

  typedef struct {
    logic [31:0] epoch;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } datetime_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  datetime_t pending_dates[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;

  seconds_to_datetime_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_epoch_seconds(in_epoch_seconds),
    .out_valid       (out_valid),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second)
  );

  always #5 clk = ~clk;

  // simple leap rule: every fourth year, no century correction
  function automatic bit is_leap(input int unsigned yr);
    return (yr & 3) == 0;
  endfunction

  // month index counts from 0
  function automatic int unsigned days_in_month(input int unsigned idx, input bit leap);
    case (idx)
      1: begin
        return leap ? 29 : 28;
      end
      3, 5, 8, 10: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // calendar date and time of day for a count of seconds
  function automatic datetime_t to_calendar(input logic [31:0] secs);
    datetime_t   r;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned len;
    bit          found;
    r.epoch = secs;
    days = secs / SECS_IN_DAY + 1;
    rem = secs % SECS_IN_DAY;
    r.hour = 5'(rem / SECS_IN_HOUR);
    rem = rem % SECS_IN_HOUR;
    r.minute = 6'(rem / SECS_IN_MIN);
    r.second = 6'(rem % SECS_IN_MIN);
    // strip whole years
    yr = EPOCH_YEAR;
    while (days > (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    // walk the months
    r.month = 4'd12;
    found = 1'b0;
    for (int unsigned m = 0; m < 12 && !found; m++) begin
      len = days_in_month(m, is_leap(yr));
      if (days <= len) begin
        r.month = 4'(m + 1);
        found = 1'b1;
      end else begin
        days -= len;
      end
    end
    r.year = 12'(yr);
    r.day = 5'(days);
    return r;
  endfunction

  // seconds count of a calendar instant, wraps past 32 bits
  function automatic logic [31:0] epoch_of(input int unsigned yr, input int unsigned mon,
                                           input int unsigned dy, input int unsigned hh,
                                           input int unsigned mm, input int unsigned ss);
    longint unsigned days;
    days = 0;
    for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
      days += is_leap(y) ? 366 : 365;
    end
    for (int unsigned m = 0; m + 1 < mon; m++) begin
      days += days_in_month(m, is_leap(yr));
    end
    days += dy - 1;
    return 32'(days * SECS_IN_DAY + hh * SECS_IN_HOUR + mm * SECS_IN_MIN + ss);
  endfunction

  // idle length before a beat, mostly short
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      return 0;
    end else if (sel < 93) begin
      return $urandom_range(1, 4);
    end else begin
      return $urandom_range(30, 260);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] epoch,
                                 input int got, input int want);
    $display("mismatch %s for epoch %0d: got %0d expected %0d", what, epoch, got, want);
    mismatch_count++;
  endtask

  // send one beat, queue its expected date once taken
  task automatic convert(input logic [31:0] secs, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    pending_dates.push_back(to_calendar(secs));
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    datetime_t want;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, year", 32'd0, int'(out_year), 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_year !== want.year)
          report_mismatch("year", want.epoch, int'(out_year), int'(want.year));
        if (out_month !== want.month)
          report_mismatch("month", want.epoch, int'(out_month), int'(want.month));
        if (out_day !== want.day)
          report_mismatch("day", want.epoch, int'(out_day), int'(want.day));
        if (out_hour !== want.hour)
          report_mismatch("hour", want.epoch, int'(out_hour), int'(want.hour));
        if (out_minute !== want.minute)
          report_mismatch("minute", want.epoch, int'(out_minute), int'(want.minute));
        if (out_second !== want.second)
          report_mismatch("second", want.epoch, int'(out_second), int'(want.second));
      end
    end
  end

  // watchdog on cycles with no beat taken and no result shown
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_dates.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // field extremes and bit patterns
  task automatic test_field_extremes();
    convert(32'd0, 0);
    convert(32'hFFFF_FFFF, 0);
    convert(32'hAAAA_AAAA, 2);
    convert(32'h5555_5555, 0);
    convert(32'd59, 0);
    convert(32'd60, 1);
    convert(32'd3599, 0);
    convert(32'd3600, 0);
    convert(32'd86399, 3);
    convert(32'd86400, 0);
  endtask

  // february edges, including 2100 counted as leap
  task automatic test_leap_rule();
    convert(epoch_of(1972, 2, 28, 23, 59, 59), 0);
    convert(epoch_of(1972, 2, 29, 0, 0, 0), 0);
    convert(epoch_of(1972, 3, 1, 0, 0, 0), 5);
    convert(epoch_of(1973, 2, 28, 23, 59, 59), 0);
    convert(epoch_of(1973, 3, 1, 0, 0, 0), 0);
    convert(epoch_of(2100, 2, 29, 12, 0, 0), 1);
    convert(epoch_of(2100, 3, 1, 0, 0, 0), 0);
    convert(epoch_of(2099, 12, 31, 23, 59, 59), 0);
  endtask

  // year rollovers and the top of the range
  task automatic test_year_ends();
    convert(epoch_of(1970, 12, 31, 23, 59, 59), 0);
    convert(epoch_of(2105, 12, 31, 23, 59, 59), 40);
    convert(epoch_of(2106, 1, 1, 0, 0, 0), 0);
    convert(32'h7FFF_FFFF, 0);
    convert(32'h8000_0000, 0);
  endtask

  // random instants, weighted toward day, month and year edges
  task automatic test_random_epochs(input int count);
    int          sel;
    int          gap;
    int unsigned yr;
    int unsigned mon;
    int unsigned dy;
    logic [31:0] secs;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      yr = $urandom_range(EPOCH_YEAR, 2105);
      mon = $urandom_range(1, 12);
      if (sel < 4) begin
        secs = $urandom;
      end else if (sel < 6) begin
        secs = $urandom_range(0, 49709) * SECS_IN_DAY;
        secs += $urandom_range(0, 1) ? SECS_IN_DAY - 1 : $urandom_range(0, SECS_IN_DAY - 1);
      end else if (sel < 8) begin
        dy = $urandom_range(0, 1) ? 1 : days_in_month(mon - 1, is_leap(yr));
        secs = epoch_of(yr, mon, dy, $urandom_range(0, 23), $urandom_range(0, 59),
                        $urandom_range(0, 59));
      end else if (sel == 8) begin
        secs = epoch_of(yr, 12, 31, 23, 59, 59);
      end else begin
        secs = epoch_of(yr, 1, 1, 0, 0, 0);
      end
      // every third stretch runs back to back
      gap = ((i / 150) % 3 == 2) ? 0 : pick_gap();
      convert(secs, gap);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_leap_rule();
    test_year_ends();
    test_random_epochs(RANDOM_BEATS);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
